### hdl/wia_pkg.sv
// ----------------------------------------------------------------------------
// wia_pkg
// shared constants and opcode type for the wrapped interval alu
// ----------------------------------------------------------------------------
package wia_pkg;

    localparam int WIDTH_DEFAULT = 32;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int CNT_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_OVERLAP = 2'd0,
        OP_ADD     = 2'd1,
        OP_SUB     = 2'd2,
        OP_MUL     = 2'd3
    } op_t;

endpackage

### hdl/wrapped_interval_alu_core.sv
// ----------------------------------------------------------------------------
// wrapped_interval_alu_core
// overlap count, add, subtract and multiply on two wrapped intervals
// ----------------------------------------------------------------------------
//  channel   signals                                          handshake
//  input     opcode a_low a_high a_wrapped b_low b_high       start & !busy
//            b_wrapped
//  result    overlap_count res_low res_high res_wrapped       done, one cycle
//            res_valid
//
//  one word accepted per cycle, result strobed through va_reg, vb_reg, vc_reg, vd_reg and done_reg
//  the five register stages are input, operand prep, add and partial products,
//  product sum, product range check and output
//  busy is high during reset and drops at the first clock after it, otherwise low
//  the pipeline never stalls; the stage valid bits and done clear on reset
// ----------------------------------------------------------------------------
module wrapped_interval_alu_core #(
    parameter int WIDTH = wia_pkg::WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [wia_pkg::OP_W-1:0]     opcode,
    input  logic [wia_pkg::DATA_W-1:0]   a_low,
    input  logic [wia_pkg::DATA_W-1:0]   a_high,
    input  logic                         a_wrapped,
    input  logic [wia_pkg::DATA_W-1:0]   b_low,
    input  logic [wia_pkg::DATA_W-1:0]   b_high,
    input  logic                         b_wrapped,
    output logic                         done,
    output logic [wia_pkg::CNT_W-1:0]    overlap_count,
    output logic [wia_pkg::DATA_W-1:0]   res_low,
    output logic [wia_pkg::DATA_W-1:0]   res_high,
    output logic                         res_wrapped,
    output logic                         res_valid
);
    import wia_pkg::*;

    localparam int XW    = WIDTH + 1;
    localparam int PW    = 2 * WIDTH + 2;
    localparam int HL    = (WIDTH + 2) / 2;
    localparam int HH    = XW - HL;
    localparam int PPL_W = HL + XW;
    localparam int PPH_W = HH + XW;

    typedef struct packed {
        op_t              op;
        logic [WIDTH-1:0] al;
        logic [WIDTH-1:0] ah;
        logic             ac;
        logic [WIDTH-1:0] bl;
        logic [WIDTH-1:0] bh;
        logic             bc;
    } stg_a_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] cnt;
        logic [WIDTH-1:0] l_min;
        logic [WIDTH-1:0] l_max;
        logic [WIDTH-1:0] r_min;
        logic [WIDTH-1:0] r_max;
        logic [1:0]       cmax0;
        logic [XW-1:0]    xa_min;
        logic [XW-1:0]    xa_max;
        logic [XW-1:0]    xb_min;
        logic [XW-1:0]    xb_max;
    } stg_b_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] cnt;
        logic [XW-1:0]    s_min;
        logic [XW-1:0]    s_max;
        logic [1:0]       cmax0;
        logic [PPL_W-1:0] pmin_l;
        logic [PPH_W-1:0] pmin_h;
        logic [PPL_W-1:0] pmax_l;
        logic [PPH_W-1:0] pmax_h;
    } stg_c_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] cnt;
        logic [WIDTH-1:0] add_lo;
        logic [WIDTH-1:0] add_hi;
        logic             add_wr;
        logic             add_vld;
        logic [PW-1:0]    pmin;
        logic [PW-1:0]    pmax;
    } stg_d_t;

    // pipeline registers
    logic             busy_reg, busy_next;
    logic             va_reg, vb_reg, vc_reg, vd_reg, done_reg;
    stg_a_t           sa_reg, sa_next;
    stg_b_t           sb_reg, sb_next;
    stg_c_t           sc_reg, sc_next;
    stg_d_t           sd_reg, sd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] lo_reg, lo_next;
    logic [WIDTH-1:0] hi_reg, hi_next;
    logic             wr_reg, wr_next;
    logic             vld_reg, vld_next;

    logic             accept;

    assign busy_next = 1'b0;
    assign accept    = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            va_reg   <= accept;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vd_reg   <= vc_reg;
            done_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sa_reg <= sa_next;
        if (va_reg)
            sb_reg <= sb_next;
        if (vb_reg)
            sc_reg <= sc_next;
        if (vc_reg)
            sd_reg <= sd_next;
        if (vd_reg)
        begin
            cnt_reg <= cnt_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            wr_reg  <= wr_next;
            vld_reg <= vld_next;
        end
    end

    // input capture, bounds taken modulo 2^WIDTH
    always_comb
    begin
        sa_next.op = op_t'(opcode);
        sa_next.al = WIDTH'(a_low);
        sa_next.ah = WIDTH'(a_high);
        sa_next.ac = a_wrapped;
        sa_next.bl = WIDTH'(b_low);
        sa_next.bh = WIDTH'(b_high);
        sa_next.bc = b_wrapped;
    end

    // operand prep: overlap count, negation, widening
    always_comb
    begin
        logic [WIDTH-1:0] ol, oh, pl, ph, mx_l, mn_h;
        logic             oc, pc, meets;
        logic [WIDTH-1:0] n_min, n_max, rl, rh;
        logic             rc;

        // overlap: put the plain interval first
        if (sa_reg.ac && !sa_reg.bc)
        begin
            ol = sa_reg.bl; oh = sa_reg.bh; oc = sa_reg.bc;
            pl = sa_reg.al; ph = sa_reg.ah; pc = sa_reg.ac;
        end
        else
        begin
            ol = sa_reg.al; oh = sa_reg.ah; oc = sa_reg.ac;
            pl = sa_reg.bl; ph = sa_reg.bh; pc = sa_reg.bc;
        end
        mx_l = (ol > pl) ? ol : pl;
        mn_h = (oh < ph) ? oh : ph;
        if (oc && pc)
            meets = 1'b1;
        else if (pc)
            meets = (ol <= pl) || (ph <= oh);
        else
            meets = (ol <= ph) && (pl <= oh);

        sb_next.op = sa_reg.op;
        if (!meets)
            sb_next.cnt = CNT_W'(0);
        else if (!oc && !pc)
            sb_next.cnt = CNT_W'(1);
        else if (oc && pc)
            sb_next.cnt = (mx_l >= mn_h) ? CNT_W'(2) : CNT_W'(1);
        else
            sb_next.cnt = ((ol <= pl) && (ph <= oh)) ? CNT_W'(2) : CNT_W'(1);

        // right operand, negated for subtract
        n_min = WIDTH'(0) - sa_reg.bl;
        n_max = WIDTH'(0) - sa_reg.bh;
        if (sa_reg.op == OP_SUB)
        begin
            if (n_min < n_max)
            begin
                rl = n_min; rh = n_max; rc = !sa_reg.bc;
            end
            else
            begin
                rl = n_max; rh = n_min; rc = sa_reg.bc;
            end
        end
        else
        begin
            rl = sa_reg.bl; rh = sa_reg.bh; rc = sa_reg.bc;
        end

        sb_next.l_min = sa_reg.ac ? sa_reg.ah : sa_reg.al;
        sb_next.l_max = sa_reg.ac ? sa_reg.al : sa_reg.ah;
        sb_next.r_min = rc ? rh : rl;
        sb_next.r_max = rc ? rl : rh;
        sb_next.cmax0 = 2'(sa_reg.ac) + 2'(rc);

        // widened ends for multiply
        sb_next.xa_min = sa_reg.ac ? {1'b0, sa_reg.ah} : {1'b0, sa_reg.al};
        sb_next.xa_max = sa_reg.ac ? {1'b1, sa_reg.al} : {1'b0, sa_reg.ah};
        sb_next.xb_min = sa_reg.bc ? {1'b0, sa_reg.bh} : {1'b0, sa_reg.bl};
        sb_next.xb_max = sa_reg.bc ? {1'b1, sa_reg.bl} : {1'b0, sa_reg.bh};
    end

    // end sums and partial products
    always_comb
    begin
        sc_next.op     = sb_reg.op;
        sc_next.cnt    = sb_reg.cnt;
        sc_next.s_min  = {1'b0, sb_reg.l_min} + {1'b0, sb_reg.r_min};
        sc_next.s_max  = {1'b0, sb_reg.l_max} + {1'b0, sb_reg.r_max};
        sc_next.cmax0  = sb_reg.cmax0;
        sc_next.pmin_l = PPL_W'(sb_reg.xa_min[HL-1:0]) * PPL_W'(sb_reg.xb_min);
        sc_next.pmin_h = PPH_W'(sb_reg.xa_min[XW-1:HL]) * PPH_W'(sb_reg.xb_min);
        sc_next.pmax_l = PPL_W'(sb_reg.xa_max[HL-1:0]) * PPL_W'(sb_reg.xb_max);
        sc_next.pmax_h = PPH_W'(sb_reg.xa_max[XW-1:HL]) * PPH_W'(sb_reg.xb_max);
    end

    // add decision and product sums
    always_comb
    begin
        logic [WIDTH-1:0] s_lo, s_hi;
        logic [1:0]       c_min, c_max;

        s_lo  = sc_reg.s_min[WIDTH-1:0];
        s_hi  = sc_reg.s_max[WIDTH-1:0];
        c_min = 2'(sc_reg.s_min[WIDTH]);
        c_max = sc_reg.cmax0 + 2'(sc_reg.s_max[WIDTH]);

        sd_next.op      = sc_reg.op;
        sd_next.cnt     = sc_reg.cnt;
        sd_next.add_lo  = '0;
        sd_next.add_hi  = '0;
        sd_next.add_wr  = 1'b0;
        sd_next.add_vld = 1'b0;
        if ((s_lo > s_hi) && (c_max == c_min + 2'd1))
        begin
            sd_next.add_lo  = s_hi;
            sd_next.add_hi  = s_lo;
            sd_next.add_wr  = 1'b1;
            sd_next.add_vld = 1'b1;
        end
        else if ((s_lo <= s_hi) && (c_min == c_max))
        begin
            sd_next.add_lo  = s_lo;
            sd_next.add_hi  = s_hi;
            sd_next.add_vld = 1'b1;
        end

        sd_next.pmin = PW'(sc_reg.pmin_l) + (PW'(sc_reg.pmin_h) << HL);
        sd_next.pmax = PW'(sc_reg.pmax_l) + (PW'(sc_reg.pmax_h) << HL);
    end

    // product range check and result select
    always_comb
    begin
        logic [PW-1:0]    diff;
        logic             mul_ok;
        logic [WIDTH-1:0] mn, mx;

        diff   = sd_reg.pmax - sd_reg.pmin;
        mul_ok = diff < PW'({WIDTH{1'b1}});
        mn     = sd_reg.pmin[WIDTH-1:0];
        mx     = sd_reg.pmax[WIDTH-1:0];

        cnt_next = '0;
        lo_next  = '0;
        hi_next  = '0;
        wr_next  = 1'b0;
        vld_next = 1'b0;
        case (sd_reg.op)
            OP_OVERLAP:
            begin
                cnt_next = sd_reg.cnt;
            end
            OP_ADD, OP_SUB:
            begin
                lo_next  = sd_reg.add_lo;
                hi_next  = sd_reg.add_hi;
                wr_next  = sd_reg.add_wr;
                vld_next = sd_reg.add_vld;
            end
            OP_MUL:
            begin
                if (mul_ok)
                begin
                    vld_next = 1'b1;
                    if (mx < mn)
                    begin
                        lo_next = mx;
                        hi_next = mn;
                        wr_next = 1'b1;
                    end
                    else
                    begin
                        lo_next = mn;
                        hi_next = mx;
                    end
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign overlap_count = cnt_reg;
    assign res_low       = DATA_W'(lo_reg);
    assign res_high      = DATA_W'(hi_reg);
    assign res_wrapped   = wr_reg;
    assign res_valid     = vld_reg;

endmodule

### hdl/wia_checker.sv
// ----------------------------------------------------------------------------
// wia_checker
// port level checks on the wrapped interval alu, bound to the core
// ----------------------------------------------------------------------------
module wia_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [wia_pkg::OP_W-1:0]     opcode,
    input logic                         done,
    input logic [wia_pkg::CNT_W-1:0]    overlap_count,
    input logic [wia_pkg::DATA_W-1:0]   res_low,
    input logic [wia_pkg::DATA_W-1:0]   res_high,
    input logic                         res_wrapped,
    input logic                         res_valid
);
    import wia_pkg::*;

    // every result word comes from a word accepted earlier on the input port
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without matching input word");

    // overlap words carry no interval
    a_overlap_no_interval: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(opcode, 5) == OP_OVERLAP) |->
            !res_valid && !res_wrapped && (res_low == '0) && (res_high == '0))
        else $error("interval result on overlap word");

    // arithmetic words carry no count
    a_arith_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(opcode, 5) != OP_OVERLAP) |-> (overlap_count == '0))
        else $error("overlap count on arithmetic word");

    // no constraint means an all-zero interval
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !res_valid |-> !res_wrapped && (res_low == '0) && (res_high == '0))
        else $error("nonzero interval without constraint");

endmodule

bind wrapped_interval_alu_core wia_checker u_wia_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .done          (done),
    .overlap_count (overlap_count),
    .res_low       (res_low),
    .res_high      (res_high),
    .res_wrapped   (res_wrapped),
    .res_valid     (res_valid)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// directed and random words through the start/busy port, each result word
// checked field by field against a local interval arithmetic predictor
// ----------------------------------------------------------------------------
module testbench;

    import wia_pkg::*;

    localparam int DW           = DATA_W;
    localparam int EXT_W        = 2 * DW + 2;
    localparam int PROD_W       = 2 * EXT_W;
    localparam int RANDOM_WORDS = 1350;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;

    localparam logic [DW-1:0]    MAXV           = '1;
    localparam logic [EXT_W-1:0] MUL_SPAN_LIMIT = (EXT_W'(1) << DW) - EXT_W'(1);

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [DW-1:0]    lo;
        logic [DW-1:0]    hi;
        logic             wr;
        logic             vld;
    } interval_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    opcode;
    logic [DW-1:0]      a_low;
    logic [DW-1:0]      a_high;
    logic               a_wrapped;
    logic [DW-1:0]      b_low;
    logic [DW-1:0]      b_high;
    logic               b_wrapped;
    logic               done;
    logic [CNT_W-1:0]   overlap_count;
    logic [DW-1:0]      res_low;
    logic [DW-1:0]      res_high;
    logic               res_wrapped;
    logic               res_valid;

    interval_result_t   expected_q[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 idle_max    = 12;

    wrapped_interval_alu_core #(
        .WIDTH(WIDTH_DEFAULT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .a_low(a_low),
        .a_high(a_high),
        .a_wrapped(a_wrapped),
        .b_low(b_low),
        .b_high(b_high),
        .b_wrapped(b_wrapped),
        .done(done),
        .overlap_count(overlap_count),
        .res_low(res_low),
        .res_high(res_high),
        .res_wrapped(res_wrapped),
        .res_valid(res_valid)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] count_shared(
        input logic [DW-1:0] al_in, input logic [DW-1:0] ah_in, input logic ac_in,
        input logic [DW-1:0] bl_in, input logic [DW-1:0] bh_in, input logic bc_in
    );
        logic [DW-1:0] al, ah, bl, bh, lmax, umin;
        logic          ac, bc, meets;
        al = al_in; ah = ah_in; ac = ac_in;
        bl = bl_in; bh = bh_in; bc = bc_in;
        if (ac && !bc)
        begin
            al = bl_in; ah = bh_in; bl = al_in; bh = ah_in;
            ac = 1'b0;  bc = 1'b1;
        end
        if (ac && bc)
            meets = 1'b1;
        else if (bc)
            meets = (al <= bl) || (bh <= ah);
        else
            meets = (al <= bh) && (bl <= ah);
        if (!meets)
            return CNT_W'(0);
        if (!ac && !bc)
            return CNT_W'(1);
        if (ac && bc)
        begin
            lmax = (al > bl) ? al : bl;
            umin = (ah < bh) ? ah : bh;
            return (lmax >= umin) ? CNT_W'(2) : CNT_W'(1);
        end
        return (al <= bl && bh <= ah) ? CNT_W'(2) : CNT_W'(1);
    endfunction

    function automatic interval_result_t add_intervals(
        input logic [DW-1:0] al, input logic [DW-1:0] ah, input logic ac,
        input logic [DW-1:0] bl, input logic [DW-1:0] bh, input logic bc
    );
        logic [DW-1:0]    smin, smax, xmin, xmax;
        logic [DW:0]      sum;
        int unsigned      cmin, cmax;
        interval_result_t r;
        r    = '0;
        cmin = 0;
        cmax = ac ? 1 : 0;
        smin = ac ? ah : al;
        smax = ac ? al : ah;
        xmin = bc ? bh : bl;
        xmax = bc ? bl : bh;
        sum  = {1'b0, smin} + {1'b0, xmin};
        cmin = cmin + 32'(sum[DW]);
        smin = sum[DW-1:0];
        sum  = {1'b0, smax} + {1'b0, xmax};
        cmax = cmax + 32'(sum[DW]);
        smax = sum[DW-1:0];
        if (bc)
            cmax = cmax + 1;
        if (smin > smax && cmax == cmin + 1)
        begin
            r.lo = smax; r.hi = smin; r.wr = 1'b1; r.vld = 1'b1;
        end
        else if (smin <= smax && cmin == cmax)
        begin
            r.lo = smin; r.hi = smax; r.vld = 1'b1;
        end
        return r;
    endfunction

    function automatic interval_result_t mul_intervals(
        input logic [DW-1:0] al, input logic [DW-1:0] ah, input logic ac,
        input logic [DW-1:0] bl, input logic [DW-1:0] bh, input logic bc
    );
        logic [EXT_W-1:0]  amin, amax, bmin, bmax, span;
        logic [PROD_W-1:0] pmin, pmax;
        logic [DW-1:0]     mn, mx;
        interval_result_t  r;
        r    = '0;
        amin = ac ? EXT_W'(ah) : EXT_W'(al);
        amax = ac ? EXT_W'(al) + (EXT_W'(1) << DW) : EXT_W'(ah);
        bmin = bc ? EXT_W'(bh) : EXT_W'(bl);
        bmax = bc ? EXT_W'(bl) + (EXT_W'(1) << DW) : EXT_W'(bh);
        pmin = PROD_W'(amin) * PROD_W'(bmin);
        pmax = PROD_W'(amax) * PROD_W'(bmax);
        span = pmax[EXT_W-1:0] - pmin[EXT_W-1:0];
        if (span < MUL_SPAN_LIMIT)
        begin
            mn    = pmin[DW-1:0];
            mx    = pmax[DW-1:0];
            r.vld = 1'b1;
            if (mx < mn)
            begin
                r.lo = mx; r.hi = mn; r.wr = 1'b1;
            end
            else
            begin
                r.lo = mn; r.hi = mx;
            end
        end
        return r;
    endfunction

    function automatic interval_result_t predict_interval(
        input op_t op,
        input logic [DW-1:0] al, input logic [DW-1:0] ah, input logic ac,
        input logic [DW-1:0] bl, input logic [DW-1:0] bh, input logic bc
    );
        logic [DW-1:0]    nmin, nmax, t;
        logic             nc;
        interval_result_t r;
        r = '0;
        case (op)
            OP_OVERLAP: r.cnt = count_shared(al, ah, ac, bl, bh, bc);
            OP_ADD:     r = add_intervals(al, ah, ac, bl, bh, bc);
            OP_SUB:
            begin
                nmin = -bl;
                nmax = -bh;
                nc   = bc;
                if (nmin < nmax)
                begin
                    t = nmin; nmin = nmax; nmax = t;
                    nc = !nc;
                end
                r = add_intervals(al, ah, ac, nmax, nmin, nc);
            end
            default:    r = mul_intervals(al, ah, ac, bl, bh, bc);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [DW-1:0] got,
                               input logic [DW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        interval_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no word outstanding");
            else
            begin
                want = expected_q.pop_front();
                check_field("overlap_count", DW'(overlap_count), DW'(want.cnt));
                check_field("res_low", res_low, want.lo);
                check_field("res_high", res_high, want.hi);
                check_field("res_wrapped", DW'(res_wrapped), DW'(want.wr));
                check_field("res_valid", DW'(res_valid), DW'(want.vld));
            end
        end
        if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
            expected_q.push_back(predict_interval(op_t'(opcode), a_low, a_high,
                                                  a_wrapped, b_low, b_high, b_wrapped));
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_word(
        input op_t op,
        input logic [DW-1:0] al, input logic [DW-1:0] ah, input logic aw,
        input logic [DW-1:0] bl, input logic [DW-1:0] bh, input logic bw
    );
        int gap;
        opcode    <= op;
        a_low     <= al;
        a_high    <= ah;
        a_wrapped <= aw;
        b_low     <= bl;
        b_high    <= bh;
        b_wrapped <= bw;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            // junk on the fields while idle
            start     <= 1'b0;
            opcode    <= OP_W'($urandom());
            a_low     <= $urandom();
            a_high    <= $urandom();
            a_wrapped <= 1'($urandom());
            b_low     <= $urandom();
            b_high    <= $urandom();
            b_wrapped <= 1'($urandom());
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_overlap_count();
        send_word(OP_OVERLAP, 10, 20, 1'b0, 30, 40, 1'b0);
        send_word(OP_OVERLAP, 0, MAXV, 1'b0, MAXV, MAXV, 1'b0);
        send_word(OP_OVERLAP, 100, 200, 1'b1, 150, 300, 1'b1);
        send_word(OP_OVERLAP, 300, 200, 1'b1, 100, 250, 1'b1);
        send_word(OP_OVERLAP, 10, 1000, 1'b1, 5, 2000, 1'b0);
        send_word(OP_OVERLAP, 20, 30, 1'b0, 10, 40, 1'b1);
        send_word(OP_OVERLAP, 0, 15, 1'b0, 10, 40, 1'b1);
    endtask

    task automatic test_add();
        send_word(OP_ADD, 1, 2, 1'b0, 3, 4, 1'b0);
        send_word(OP_ADD, MAXV, MAXV, 1'b0, 1, 1, 1'b0);
        send_word(OP_ADD, MAXV - 1, MAXV, 1'b0, 0, 1, 1'b0);
        send_word(OP_ADD, 0, MAXV, 1'b0, 1, 1, 1'b0);
        send_word(OP_ADD, 5, MAXV - 5, 1'b1, 1, 1, 1'b0);
        send_word(OP_ADD, 50, 10, 1'b0, 0, 0, 1'b0);
        send_word(OP_ADD, 0, MAXV, 1'b0, 0, MAXV, 1'b0);
    endtask

    task automatic test_sub();
        send_word(OP_SUB, 10, 20, 1'b0, 3, 5, 1'b0);
        send_word(OP_SUB, 10, 20, 1'b0, 0, 5, 1'b0);
        send_word(OP_SUB, 0, 0, 1'b0, 0, 0, 1'b0);
        send_word(OP_SUB, 100, MAXV - 100, 1'b1, 7, MAXV - 7, 1'b1);
        send_word(OP_SUB, MAXV, MAXV, 1'b0, MAXV, MAXV, 1'b0);
    endtask

    task automatic test_mul();
        send_word(OP_MUL, 2, 3, 1'b0, 4, 5, 1'b0);
        send_word(OP_MUL, 0, MAXV, 1'b0, 0, MAXV, 1'b0);
        send_word(OP_MUL, 3, MAXV - 2, 1'b1, 1, 1, 1'b0);
        send_word(OP_MUL, 65536, 65537, 1'b0, 65535, 65536, 1'b0);
        send_word(OP_MUL, 7, 3, 1'b0, 2, 2, 1'b0);
        send_word(OP_MUL, MAXV, MAXV, 1'b0, MAXV, MAXV, 1'b0);
    endtask

    function automatic logic [DW-1:0] pick_bound();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return MAXV;
            2:       return DW'($urandom_range(0, 15));
            3:       return MAXV - DW'($urandom_range(0, 15));
            4:       return (DW'(1) << (DW - 1)) + DW'($urandom_range(0, 15)) - DW'(8);
            default: return DW'($urandom());
        endcase
    endfunction

    task automatic pick_interval(input op_t op, output logic [DW-1:0] lo,
                                 output logic [DW-1:0] hi, output logic w);
        w  = ($urandom_range(0, 3) == 0);
        lo = pick_bound();
        case ($urandom_range(0, 3))
            0:       hi = lo + DW'($urandom_range(0, 255));
            1:       hi = pick_bound();
            2:       hi = DW'($urandom());
            default: hi = lo;
        endcase
        // keep most products narrow enough to constrain something
        if (op == OP_MUL && $urandom_range(0, 2) != 0)
        begin
            lo = DW'($urandom_range(0, 4095));
            if (w)
                hi = MAXV - DW'($urandom_range(0, 64));
            else
                hi = lo + DW'($urandom_range(0, 64));
        end
    endtask

    task automatic test_random_mix();
        op_t           op;
        logic [DW-1:0] al, ah, bl, bh;
        logic          aw, bw;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 150 == 0)
                idle_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
            op = op_t'($urandom_range(0, 3));
            pick_interval(op, al, ah, aw);
            pick_interval(op, bl, bh, bw);
            if (op == OP_MUL && $urandom_range(0, 3) == 0)
                bh = bl;
            send_word(op, al, ah, aw, bl, bh, bw);
        end
        idle_max = 12;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        opcode    <= OP_OVERLAP;
        a_low     <= '0;
        a_high    <= '0;
        a_wrapped <= 1'b0;
        b_low     <= '0;
        b_high    <= '0;
        b_wrapped <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_overlap_count();
        test_add();
        test_sub();
        test_mul();
        test_random_mix();

        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
